@@ rtl/rtf_pkg.sv @@
// shared types and constants for the radio transmit-request framer
// no dependencies
package rtf_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN      = 26;
    localparam int unsigned POS_W          = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_FIRST = '0;
    localparam logic [POS_W-1:0] POS_SUM_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SUM_HI = POS_W'(24);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

    // fixed frame bytes
    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] LEN_HI_BYTE  = 8'h00;
    localparam logic [7:0] LEN_LO_BYTE  = 8'd22;
    localparam logic [7:0] FRAME_TYPE   = 8'h10;
    localparam logic [7:0] FRAME_ID     = 8'h01;
    localparam logic [7:0] NET16_HI     = 8'hFF;
    localparam logic [7:0] NET16_LO     = 8'hFE;
    localparam logic [7:0] RADIUS_BYTE  = 8'h00;
    localparam logic [7:0] OPTIONS_BYTE = 8'h00;
    localparam logic [7:0] PAYLOAD_TAG  = 8'h53;
    localparam logic [7:0] PAD_BYTE     = 8'h00;

    // payload rules
    localparam logic [7:0] FIXED_CHANNEL = 8'h01;
    localparam logic [7:0] DIMMER_FULL   = 8'd100;
    localparam logic [7:0] DIMMER_CAP    = 8'd99;

    // configuration port
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ADDR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CURTAIN_ADDR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIMMER_ADDR  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_ADDR  = CFG_IDX_W'(3);

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        CMD_SWITCH  = 2'd0,
        CMD_CURTAIN = 2'd1,
        CMD_DIMMER  = 2'd2,
        CMD_COLOUR  = 2'd3
    } cmd_t;

    // classified request, ready to be serialized
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [7:0]        channel;
        logic [7:0]        level;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } rtf_rec_t;

endpackage

@@ rtl/rtf_front.sv @@
// front part: address registers and request classification
// depends on rtf_pkg
module rtf_front
    import rtf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [1:0]           cmd,
    input  logic [7:0]           channel,
    input  logic [7:0]           level,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic                 queue_full,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 cfg_ready,
    output logic                 rec_write,
    output rtf_rec_t             rec
);

    logic [ADDR_W-1:0] switch_addr_reg;
    logic [ADDR_W-1:0] curtain_addr_reg;
    logic [ADDR_W-1:0] dimmer_addr_reg;
    logic [ADDR_W-1:0] colour_addr_reg;
    cmd_t              kind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_addr_reg  <= '0;
            curtain_addr_reg <= '0;
            dimmer_addr_reg  <= '0;
            colour_addr_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SWITCH_ADDR:  switch_addr_reg  <= cfg_data;
                REG_CURTAIN_ADDR: curtain_addr_reg <= cfg_data;
                REG_DIMMER_ADDR:  dimmer_addr_reg  <= cfg_data;
                REG_COLOUR_ADDR:  colour_addr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign kind      = cmd_t'(cmd);
    assign rec_write = push && !queue_full;

    always_comb
    begin
        rec.red   = 8'h00;
        rec.green = 8'h00;
        rec.blue  = 8'h00;
        unique case (kind)
            CMD_SWITCH:
            begin
                rec.dest    = switch_addr_reg;
                rec.channel = channel;
                rec.level   = level;
            end
            CMD_CURTAIN:
            begin
                rec.dest    = curtain_addr_reg;
                rec.channel = channel;
                rec.level   = level;
            end
            CMD_DIMMER:
            begin
                rec.dest    = dimmer_addr_reg;
                rec.channel = FIXED_CHANNEL;
                rec.level   = (level == DIMMER_FULL) ? DIMMER_CAP : level;
            end
            CMD_COLOUR:
            begin
                rec.dest    = colour_addr_reg;
                rec.channel = FIXED_CHANNEL;
                rec.level   = 8'h00;
                rec.red     = red;
                rec.green   = green;
                rec.blue    = blue;
            end
            default:
            begin
                rec.dest    = switch_addr_reg;
                rec.channel = channel;
                rec.level   = level;
            end
        endcase
    end

endmodule

@@ rtl/rtf_queue.sv @@
// short request queue between the front and back parts
// depends on rtf_pkg
module rtf_queue
    import rtf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  rtf_rec_t wr_rec,
    output logic     full,
    input  logic     rd_en,
    output logic     rec_valid,
    output rtf_rec_t rd_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rtf_rec_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign rec_valid = (count_reg != '0);
    assign rd_rec    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/rtf_back.sv @@
// back part: serializes one request into frame bytes with checksum
// depends on rtf_pkg
module rtf_back
    import rtf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_valid,
    input  rtf_rec_t   rec,
    output logic       rec_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] frame_byte,
    output logic       last_byte
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             advance;
    logic [7:0]       cur_byte;

    // output slot frees when empty or being taken this cycle
    assign advance = rec_valid && (!out_valid_reg || pop);
    assign rec_pop = advance && (pos_reg == POS_LAST);

    always_comb
    begin
        unique case (pos_reg)
            POS_W'(0):  cur_byte = START_BYTE;
            POS_W'(1):  cur_byte = LEN_HI_BYTE;
            POS_W'(2):  cur_byte = LEN_LO_BYTE;
            POS_W'(3):  cur_byte = FRAME_TYPE;
            POS_W'(4):  cur_byte = FRAME_ID;
            POS_W'(5):  cur_byte = rec.dest[63:56];
            POS_W'(6):  cur_byte = rec.dest[55:48];
            POS_W'(7):  cur_byte = rec.dest[47:40];
            POS_W'(8):  cur_byte = rec.dest[39:32];
            POS_W'(9):  cur_byte = rec.dest[31:24];
            POS_W'(10): cur_byte = rec.dest[23:16];
            POS_W'(11): cur_byte = rec.dest[15:8];
            POS_W'(12): cur_byte = rec.dest[7:0];
            POS_W'(13): cur_byte = NET16_HI;
            POS_W'(14): cur_byte = NET16_LO;
            POS_W'(15): cur_byte = RADIUS_BYTE;
            POS_W'(16): cur_byte = OPTIONS_BYTE;
            POS_W'(17): cur_byte = PAYLOAD_TAG;
            POS_W'(18): cur_byte = rec.channel;
            POS_W'(19): cur_byte = rec.level;
            POS_W'(20): cur_byte = rec.red;
            POS_W'(21): cur_byte = rec.green;
            POS_W'(22): cur_byte = rec.blue;
            POS_W'(23): cur_byte = PAD_BYTE;
            POS_W'(24): cur_byte = PAD_BYTE;
            POS_W'(25): cur_byte = ~sum_reg;
            default:    cur_byte = PAD_BYTE;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (advance)
        begin
            pos_next = (pos_reg == POS_LAST) ? POS_FIRST : pos_reg + POS_W'(1);
            if (pos_reg == POS_FIRST)
                sum_next = 8'h00;
            else if (pos_reg >= POS_SUM_LO && pos_reg <= POS_SUM_HI)
                sum_next = sum_reg + cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FIRST;
            sum_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= (pos_reg == POS_LAST);
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            byte_reg <= cur_byte;
    end

    assign empty      = !out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte position past end of frame");

    a_last_marks_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (last_reg == ($past(pos_reg) == POS_LAST)))
        else $error("last flag does not match checksum position");

    a_pop_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |=> (pos_reg == POS_FIRST))
        else $error("request retired away from frame end");

    a_sum_cleared_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pos_reg == POS_FIRST) |=> (sum_reg == 8'h00))
        else $error("checksum not cleared at frame start");

endmodule

@@ rtl/radio_api_transmit_framer.sv @@
// top level of the radio transmit-request framer
// depends on rtf_pkg, rtf_front, rtf_queue, rtf_back
//
// a request is queued, then its first frame byte is registered onto the result ports
// one frame byte per cycle from the back sequencer, given a queued request
// the output register takes a new byte whenever it is empty or being popped
// reset (async, active low) clears address registers, queue and sequencer
module radio_api_transmit_framer
    import rtf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request side
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           cmd,
    input  logic [7:0]           channel,
    input  logic [7:0]           level,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           frame_byte,
    output logic                 last_byte,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    // classified request from front to queue
    rtf_rec_t wr_rec;
    logic     wr_en;
    // queue head toward the back sequencer
    rtf_rec_t head_rec;
    logic     head_valid;
    logic     head_pop;

    // front: holds the four destination registers, picks address and payload
    rtf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .channel    (channel),
        .level      (level),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .queue_full (full),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .rec_write  (wr_en),
        .rec        (wr_rec)
    );

    // queue: the request being serialized plus up to QUEUE_DEPTH-1 waiting
    rtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_rec    (wr_rec),
        .full      (full),
        .rd_en     (head_pop),
        .rec_valid (head_valid),
        .rd_rec    (head_rec)
    );

    // back: walks the 26 byte positions of the head request, then retires it
    rtf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (head_valid),
        .rec        (head_rec),
        .rec_pop    (head_pop),
        .pop        (pop),
        .empty      (empty),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule
